// ===== rtl/assert_macros.svh =====
// Assertion macros included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// invariant
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// ===== rtl/dagb_pkg.sv =====
// Types and constants for the deformable attention bilinear gather.
package dagb_pkg;

    localparam int MUL_W   = 32;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 3;
    localparam int HEAD_W  = 9;
    localparam int KEY_W   = 24;
    localparam int WT_W    = 17;

    localparam logic [0:0] CFG_HEAD_COUNT = 1'b0;
    localparam logic [0:0] CFG_KEY_COUNT  = 1'b1;

    typedef logic [MUL_W-1:0] t_word;

    typedef struct packed {
        logic [7:0]  batch_id;
        logic [7:0]  head_id;
        logic [2:0]  lvl_idx;
        logic [11:0] level_height;
        logic [11:0] level_width;
        logic [15:0] x_floor;
        logic [15:0] y_floor;
        logic [15:0] frac_x;
        logic [15:0] frac_y;
        logic [15:0] attn_weight;
        logic        query_end;
    } t_point;

endpackage

// ===== rtl/dagb_mul.sv =====
// Shared multiplier with registered low-word product.
module dagb_mul (
    input  logic                  i_clk,
    input  dagb_pkg::t_word       i_a,
    input  dagb_pkg::t_word       i_b,
    output dagb_pkg::t_word       o_p
);
    import dagb_pkg::*;

    t_word              full;
    t_word              r_p;

    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= full;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/deformable_attn_bilinear_gather.sv =====
// Bilinear corner gather for deformable attention: top level and sequencer.
//
//  channel | dir | handshake                 | payload
//  s       | in  | i_s_tvalid / o_s_tready   | i_s_tdata point, i_s_tlast query end
//  m       | out | o_m_tvalid / i_m_tready   | o_m_tdata row/weights, o_m_tuser corner
//  cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// After idle accepts a point, it runs 5 setup steps and 2 per corner (MUL, LOAD),
// all through the single shared 32x32 multiplier; LOAD holds on output stall.
// Four beats leave per point, corner 0 first; last beat carries tlast.
// The output register lets the next point be accepted while the last beat waits.
// Synchronous active-low reset clears level table, freeze flag, state, count and
// output valid, and sets head and key counts to one. Config is always ready.
`include "assert_macros.svh"

module deformable_attn_bilinear_gather #(
    parameter int MAX_LEVELS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] batch_id, [15:8] head_id, [18:16] lvl_idx, [30:19] level_height,
    // [42:31] level_width, [58:43] x_floor, [74:59] y_floor, [90:75] frac_x,
    // [106:91] frac_y, [122:107] attn_weight, [127:123] zero
    input  logic [dagb_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] value_row, [48:32] corner_wt, [64:49] attn_weight_out, [71:65] zero
    output logic [dagb_pkg::M_DATA_W-1:0]  o_m_tdata,
    // [1:0] corner, [2] corner_valid
    output logic [dagb_pkg::M_USER_W-1:0]  o_m_tuser,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_index,
    input  logic [dagb_pkg::KEY_W-1:0]     i_cfg_data
);
    import dagb_pkg::*;

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HW   = 3'd1;
    localparam logic [2:0] S_FF   = 3'd2;
    localparam logic [2:0] S_BK   = 3'd3;
    localparam logic [2:0] S_YW   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_LOAD = 3'd7;

    logic [2:0]        r_state, n_state;
    t_point            r_pt;
    logic [HEAD_W-1:0] r_heads;
    logic [KEY_W-1:0]  r_keys;
    logic [KEY_W-1:0]  r_lvl [MAX_LEVELS];
    logic              r_frozen;
    logic [KEY_W-1:0]  r_start;
    logic [WT_W-1:0]   r_pw;
    t_word             r_base;
    t_word             r_key0;
    logic [1:0]        r_cnt;

    logic              r_m_valid;
    logic [1:0]        r_corner;
    logic              r_cvalid;
    t_word             r_row;
    logic [WT_W-1:0]   r_wt;
    logic [15:0]       r_aw;
    logic              r_last;

    t_word             mul_a, mul_b, prod, key_k;
    logic [4:0]        lvl_ext, lvl_nxt;
    logic              lvl_ok, upd_ok;
    logic [32:0]       p_sum;
    logic [16:0]       cx, cy;
    logic              c_valid;
    logic [WT_W-1:0]   c_wt;
    logic              out_free;
    logic              s_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;

    assign lvl_ext = {2'b00, r_pt.lvl_idx};
    assign lvl_nxt = lvl_ext + 5'd1;
    assign lvl_ok  = lvl_ext < 5'(MAX_LEVELS);
    assign upd_ok  = lvl_nxt < 5'(MAX_LEVELS);

    assign key_k = r_key0 + (r_cnt[0] ? {20'b0, r_pt.level_width} : '0)
                 + {31'b0, r_cnt[1]};

    always_comb begin
        unique case (r_state)
            S_HW: begin
                mul_a = {20'b0, r_pt.level_height};
                mul_b = {20'b0, r_pt.level_width};
            end
            S_FF: begin
                mul_a = {16'b0, r_pt.frac_x};
                mul_b = {16'b0, r_pt.frac_y};
            end
            S_BK: begin
                mul_a = {24'b0, r_pt.batch_id};
                mul_b = {8'b0, r_keys};
            end
            S_YW: begin
                mul_a = {{16{r_pt.y_floor[15]}}, r_pt.y_floor};
                mul_b = {20'b0, r_pt.level_width};
            end
            default: begin
                mul_a = key_k;
                mul_b = {23'b0, r_heads};
            end
        endcase
    end

    dagb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign p_sum = {1'b0, prod} + 33'd32768;

    assign cx = {r_pt.x_floor[15], r_pt.x_floor} + {16'b0, r_cnt[1]};
    assign cy = {r_pt.y_floor[15], r_pt.y_floor} + {16'b0, r_cnt[0]};
    assign c_valid = !cx[16] && !cy[16]
                  && (cx < {5'b0, r_pt.level_width})
                  && (cy < {5'b0, r_pt.level_height});

    always_comb begin
        case (r_cnt)
            2'd0: c_wt = 17'h10000 - {1'b0, r_pt.frac_x} - {1'b0, r_pt.frac_y} + r_pw;
            2'd1: c_wt = {1'b0, r_pt.frac_y} - r_pw;
            2'd2: c_wt = {1'b0, r_pt.frac_x} - r_pw;
            default: c_wt = r_pw;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) begin
                n_state = S_HW;
            end
            S_HW:  n_state = S_FF;
            S_FF:  n_state = S_BK;
            S_BK:  n_state = S_YW;
            S_YW:  n_state = S_SUM;
            S_SUM: n_state = S_MUL;
            S_MUL: n_state = S_LOAD;
            S_LOAD: if (out_free) begin
                n_state = (r_cnt == 2'd3) ? S_IDLE : S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_heads  <= HEAD_W'(1);
            r_keys   <= KEY_W'(1);
            r_frozen <= 1'b0;
            r_cnt    <= 2'd0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_lvl[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_HEAD_COUNT) begin
                    r_heads <= i_cfg_data[HEAD_W-1:0];
                end else begin
                    r_keys <= i_cfg_data;
                end
            end
            if (r_state == S_FF) begin
                if (!r_frozen && upd_ok) begin
                    r_lvl[lvl_nxt[LVL_W-1:0]] <= r_start + prod[KEY_W-1:0];
                end
                if (r_pt.query_end) begin
                    r_frozen <= 1'b1;
                end
            end
            if (r_state == S_SUM) begin
                r_cnt <= 2'd0;
            end
            if (r_state == S_LOAD && out_free) begin
                r_m_valid <= 1'b1;
                r_cnt <= r_cnt + 2'd1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pt <= '{
                batch_id:     i_s_tdata[7:0],
                head_id:      i_s_tdata[15:8],
                lvl_idx:      i_s_tdata[18:16],
                level_height: i_s_tdata[30:19],
                level_width:  i_s_tdata[42:31],
                x_floor:      i_s_tdata[58:43],
                y_floor:      i_s_tdata[74:59],
                frac_x:       i_s_tdata[90:75],
                frac_y:       i_s_tdata[106:91],
                attn_weight:  i_s_tdata[122:107],
                query_end:    i_s_tlast
            };
        end
        if (r_state == S_HW) begin
            r_start <= lvl_ok ? r_lvl[lvl_ext[LVL_W-1:0]] : '0;
        end
        if (r_state == S_BK) begin
            r_pw <= p_sum[32:16];
        end
        if (r_state == S_YW) begin
            r_base <= prod + {8'b0, r_start};
        end
        if (r_state == S_SUM) begin
            r_key0 <= r_base + prod + {{16{r_pt.x_floor[15]}}, r_pt.x_floor};
        end
        if (r_state == S_LOAD && out_free) begin
            r_corner <= r_cnt;
            r_cvalid <= c_valid;
            r_row    <= c_valid ? (prod + {24'b0, r_pt.head_id}) : '0;
            r_wt     <= c_valid ? c_wt : '0;
            r_aw     <= r_pt.attn_weight;
            r_last   <= (r_cnt == 2'd3);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'b0, r_aw, r_wt, r_row};
    assign o_m_tuser  = {r_cvalid, r_corner};
    assign o_m_tlast  = r_last;

    `ASSERT_IMPLIES(a_last_is_corner3, i_clk, i_rst_n, o_m_tvalid && o_m_tlast,
        o_m_tuser[1:0] == 2'd3)
    `ASSERT_IMPLIES(a_invalid_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[2],
        o_m_tdata[48:0] == 49'd0)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_acc, !o_s_tready)
    `ASSERT_ALWAYS(a_level0_zero, i_clk, i_rst_n, r_lvl[0] == '0)

endmodule
